// ----- hdl/mck_pkg.sv -----
`timescale 1ns / 1ps

package mck_pkg;

	localparam int DurW = 16;
	localparam int CntW = 3;
	localparam int PatW = 4;
	localparam int AddrW = 4;
	localparam int DataW = 32;

	localparam logic [DurW-1:0] ResetShort = 16'd200;
	localparam logic [DurW-1:0] ResetLong = 16'd600;

	localparam logic [7:0] CodeSpace = 8'd32;
	localparam logic [7:0] CodeUpperA = 8'd65;
	localparam logic [7:0] CodeUpperZ = 8'd90;
	localparam logic [7:0] CodeLowerA = 8'd97;
	localparam logic [7:0] CodeLowerZ = 8'd122;
	localparam logic [7:0] CaseOffset = 8'd32;

	typedef enum logic [1:0] {
		REG_DOT = 2'd0,
		REG_DASH = 2'd1,
		REG_SYM_GAP = 2'd2,
		REG_LET_GAP = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		STEP_IDLE = 2'd0,
		STEP_TONE = 2'd1,
		STEP_GAP = 2'd2,
		STEP_CLOSE = 2'd3
	} step_t;

	typedef enum logic [1:0] {
		DUR_SYMBOL = 2'd0,
		DUR_SYM_GAP = 2'd1,
		DUR_LET_GAP = 2'd2
	} dur_sel_t;

	// FETCH: wait for a character and dispatch; NEXT: advance on output
	// transaction; LOOP: back to loop_step while symbols remain.
	typedef enum logic [1:0] {
		SEQ_FETCH = 2'd0,
		SEQ_NEXT = 2'd1,
		SEQ_LOOP = 2'd2
	} seq_t;

	typedef struct packed {
		logic emit;
		logic tone;
		logic lamp;
		logic last;
		dur_sel_t dur_sel;
		seq_t seq;
		step_t next_step;
		step_t loop_step;
	} ctrl_t;

	typedef struct packed {
		logic [CntW-1:0] len;
		logic [PatW-1:0] dash;  // bit 0 is the first symbol, 1 = dash
	} morse_t;

	function automatic ctrl_t ucode(input step_t s);
		ctrl_t c;
		unique case (s)
			STEP_IDLE: c = '{emit: 1'b0, tone: 1'b0, lamp: 1'b0, last: 1'b0,
				dur_sel: DUR_SYM_GAP, seq: SEQ_FETCH,
				next_step: STEP_IDLE, loop_step: STEP_IDLE};
			STEP_TONE: c = '{emit: 1'b1, tone: 1'b1, lamp: 1'b1, last: 1'b0,
				dur_sel: DUR_SYMBOL, seq: SEQ_NEXT,
				next_step: STEP_GAP, loop_step: STEP_GAP};
			STEP_GAP: c = '{emit: 1'b1, tone: 1'b0, lamp: 1'b1, last: 1'b0,
				dur_sel: DUR_SYM_GAP, seq: SEQ_LOOP,
				next_step: STEP_CLOSE, loop_step: STEP_TONE};
			STEP_CLOSE: c = '{emit: 1'b1, tone: 1'b0, lamp: 1'b0, last: 1'b1,
				dur_sel: DUR_LET_GAP, seq: SEQ_NEXT,
				next_step: STEP_IDLE, loop_step: STEP_IDLE};
			default: c = '{emit: 1'b0, tone: 1'b0, lamp: 1'b0, last: 1'b0,
				dur_sel: DUR_SYM_GAP, seq: SEQ_FETCH,
				next_step: STEP_IDLE, loop_step: STEP_IDLE};
		endcase
		return c;
	endfunction

	function automatic morse_t morse_lookup(input logic [4:0] idx);
		morse_t m;
		unique case (idx)
			5'd0:  m = '{len: 3'd2, dash: 4'b0010};
			5'd1:  m = '{len: 3'd4, dash: 4'b0001};
			5'd2:  m = '{len: 3'd4, dash: 4'b0101};
			5'd3:  m = '{len: 3'd3, dash: 4'b0001};
			5'd4:  m = '{len: 3'd1, dash: 4'b0000};
			5'd5:  m = '{len: 3'd4, dash: 4'b0100};
			5'd6:  m = '{len: 3'd3, dash: 4'b0011};
			5'd7:  m = '{len: 3'd4, dash: 4'b0000};
			5'd8:  m = '{len: 3'd2, dash: 4'b0000};
			5'd9:  m = '{len: 3'd4, dash: 4'b1110};
			5'd10: m = '{len: 3'd3, dash: 4'b0101};
			5'd11: m = '{len: 3'd4, dash: 4'b0010};
			5'd12: m = '{len: 3'd2, dash: 4'b0011};
			5'd13: m = '{len: 3'd2, dash: 4'b0001};
			5'd14: m = '{len: 3'd3, dash: 4'b0111};
			5'd15: m = '{len: 3'd4, dash: 4'b0110};
			5'd16: m = '{len: 3'd4, dash: 4'b1011};
			5'd17: m = '{len: 3'd3, dash: 4'b0010};
			5'd18: m = '{len: 3'd3, dash: 4'b0000};
			5'd19: m = '{len: 3'd1, dash: 4'b0001};
			5'd20: m = '{len: 3'd3, dash: 4'b0100};
			5'd21: m = '{len: 3'd4, dash: 4'b1000};
			5'd22: m = '{len: 3'd3, dash: 4'b0110};
			5'd23: m = '{len: 3'd4, dash: 4'b1001};
			5'd24: m = '{len: 3'd4, dash: 4'b1101};
			5'd25: m = '{len: 3'd4, dash: 4'b0011};
			default: m = '{len: 3'd1, dash: 4'b0000};
		endcase
		return m;
	endfunction

endpackage

// ----- hdl/morse_character_keyer.sv -----
`timescale 1ns / 1ps

// Morse keyer: each accepted ASCII byte (a-z folded to A-Z) becomes a stream
// of timed segments on the output channel. A letter of n symbols gives, per
// symbol, a tone segment (dot or dash time) and a silent lamp-on symbol gap,
// then a lamp-off letter gap flagged with last. A space gives one symbol gap
// and the letter gap; any other byte is taken and gives nothing. A four-step
// microcode program emits one segment per cycle while the output is ready; the
// next byte is taken only once the letter gap has gone out. Durations are in
// milliseconds and come from the four 16-bit APB registers at 0x0 dot, 0x4
// dash, 0x8 symbol gap, 0xC letter gap (reset 200/600/200/600); write them
// only while the keyer is idle.
module morse_character_keyer (
	input  logic clk,
	input  logic arst_n,
	// APB configuration
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [mck_pkg::AddrW-1:0] paddr,
	input  logic [mck_pkg::DataW-1:0] pwdata,
	output logic [mck_pkg::DataW-1:0] prdata,
	output logic pready,
	// character input
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] char_code,
	// segment output
	output logic out_valid,
	input  logic out_ready,
	output logic tone_on,
	output logic lamp_on,
	output logic [mck_pkg::DurW-1:0] duration,
	output logic last
);

	logic [mck_pkg::DurW-1:0] dot_q, dash_q, sym_gap_q, let_gap_q;
	mck_pkg::step_t step_q, step_d;
	mck_pkg::ctrl_t ctrl;
	logic [mck_pkg::CntW-1:0] cnt_q;
	logic [mck_pkg::PatW-1:0] pat_q;
	logic [7:0] upper;
	logic [4:0] letter_off;
	logic is_space, is_letter;
	mck_pkg::morse_t sym;
	logic in_xfer, out_xfer, wr_en;

	// ---- configuration registers ----
	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= mck_pkg::ResetShort;
			dash_q <= mck_pkg::ResetLong;
			sym_gap_q <= mck_pkg::ResetShort;
			let_gap_q <= mck_pkg::ResetLong;
		end else if (wr_en) begin
			unique case (mck_pkg::reg_idx_t'(paddr[3:2]))
				mck_pkg::REG_DOT: dot_q <= pwdata[mck_pkg::DurW-1:0];
				mck_pkg::REG_DASH: dash_q <= pwdata[mck_pkg::DurW-1:0];
				mck_pkg::REG_SYM_GAP: sym_gap_q <= pwdata[mck_pkg::DurW-1:0];
				mck_pkg::REG_LET_GAP: let_gap_q <= pwdata[mck_pkg::DurW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (mck_pkg::reg_idx_t'(paddr[3:2]))
			mck_pkg::REG_DOT: prdata = {16'd0, dot_q};
			mck_pkg::REG_DASH: prdata = {16'd0, dash_q};
			mck_pkg::REG_SYM_GAP: prdata = {16'd0, sym_gap_q};
			mck_pkg::REG_LET_GAP: prdata = {16'd0, let_gap_q};
			default: prdata = '0;
		endcase
	end

	// ---- character decode ----
	always_comb begin
		if (char_code >= mck_pkg::CodeLowerA && char_code <= mck_pkg::CodeLowerZ)
			upper = char_code - mck_pkg::CaseOffset;
		else
			upper = char_code;
	end

	assign is_space = (upper == mck_pkg::CodeSpace);
	assign is_letter = (upper >= mck_pkg::CodeUpperA) && (upper <= mck_pkg::CodeUpperZ);
	assign letter_off = 5'(upper - mck_pkg::CodeUpperA);
	assign sym = mck_pkg::morse_lookup(letter_off);

	// ---- sequencer ----
	assign ctrl = mck_pkg::ucode(step_q);
	assign in_ready = (ctrl.seq == mck_pkg::SEQ_FETCH);
	assign in_xfer = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	always_comb begin
		step_d = step_q;
		case (ctrl.seq)
			mck_pkg::SEQ_FETCH: begin
				if (in_valid) begin
					if (is_space)
						step_d = mck_pkg::STEP_GAP;
					else if (is_letter)
						step_d = mck_pkg::STEP_TONE;
				end
			end
			mck_pkg::SEQ_NEXT: begin
				if (out_ready)
					step_d = ctrl.next_step;
			end
			mck_pkg::SEQ_LOOP: begin
				if (out_ready)
					step_d = (cnt_q > 3'd1) ? ctrl.loop_step : ctrl.next_step;
			end
			default: step_d = mck_pkg::STEP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= mck_pkg::STEP_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	// symbol count and dash pattern; a space runs the gap step once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pat_q <= '0;
		end else if (in_xfer) begin
			cnt_q <= is_space ? 3'd1 : sym.len;
			pat_q <= sym.dash;
		end else if (out_xfer && ctrl.seq == mck_pkg::SEQ_LOOP) begin
			cnt_q <= cnt_q - 3'd1;
			pat_q <= {1'b0, pat_q[mck_pkg::PatW-1:1]};
		end
	end

	// ---- outputs ----
	always_comb begin
		out_valid = ctrl.emit;
		tone_on = ctrl.tone;
		lamp_on = ctrl.lamp;
		last = ctrl.last;
		case (ctrl.dur_sel)
			mck_pkg::DUR_SYMBOL: duration = pat_q[0] ? dash_q : dot_q;
			mck_pkg::DUR_SYM_GAP: duration = sym_gap_q;
			mck_pkg::DUR_LET_GAP: duration = let_gap_q;
			default: duration = sym_gap_q;
		endcase
	end

	// ---- assertions ----
	a_tone_then_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && tone_on |=> out_valid && !tone_on && lamp_on && !last)
		else $error("tone segment not followed by symbol gap");

	a_last_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> in_ready && !out_valid)
		else $error("keyer not idle after closing gap");

	a_letter_starts_tone: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && is_letter |=> out_valid && tone_on)
		else $error("letter did not start with a tone segment");

	a_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == mck_pkg::STEP_TONE || step_q == mck_pkg::STEP_GAP) |-> cnt_q != 3'd0)
		else $error("symbol count empty inside a character");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while segments pending");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

	typedef struct packed {
		logic tone;
		logic lamp;
		logic [mck_pkg::DurW-1:0] dur;
		logic fin;
	} seg_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [mck_pkg::AddrW-1:0] paddr = '0;
	logic [mck_pkg::DataW-1:0] pwdata = '0;
	logic [mck_pkg::DataW-1:0] prdata;
	logic pready;

	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] char_code = '0;

	logic out_valid;
	logic out_ready = 1'b0;
	logic tone_on;
	logic lamp_on;
	logic [mck_pkg::DurW-1:0] duration;
	logic last;

	// local copy of the timing registers
	logic [mck_pkg::DurW-1:0] seg_time [4];

	logic [7:0] pending_chars [$];
	seg_t segments_due [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit send_hold = 1'b0;

	int err_count = 0;
	int n_chars = 0;
	int n_segments = 0;
	int n_settings = 0;

	morse_character_keyer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_code(char_code),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.tone_on(tone_on),
		.lamp_on(lamp_on),
		.duration(duration),
		.last(last)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic string morse_pattern(input int idx);
		case (idx)
			0: return ".-";
			1: return "-...";
			2: return "-.-.";
			3: return "-..";
			4: return ".";
			5: return "..-.";
			6: return "--.";
			7: return "....";
			8: return "..";
			9: return ".---";
			10: return "-.-";
			11: return ".-..";
			12: return "--";
			13: return "-.";
			14: return "---";
			15: return ".--.";
			16: return "--.-";
			17: return ".-.";
			18: return "...";
			19: return "-";
			20: return "..-";
			21: return "...-";
			22: return ".--";
			23: return "-..-";
			24: return "-.--";
			default: return "--..";
		endcase
	endfunction

	task automatic queue_segment(input logic tone, input logic lamp,
			input logic [mck_pkg::DurW-1:0] dur, input logic fin);
		seg_t s;
		s.tone = tone;
		s.lamp = lamp;
		s.dur = dur;
		s.fin = fin;
		segments_due.push_back(s);
	endtask

	task automatic predict_segments(input logic [7:0] code);
		logic [7:0] c;
		string pat;
		c = code;
		if (c >= mck_pkg::CodeLowerA && c <= mck_pkg::CodeLowerZ)
			c = c - mck_pkg::CaseOffset;
		if (c == mck_pkg::CodeSpace) begin
			queue_segment(1'b0, 1'b1, seg_time[mck_pkg::REG_SYM_GAP], 1'b0);
			queue_segment(1'b0, 1'b0, seg_time[mck_pkg::REG_LET_GAP], 1'b1);
		end else if (c >= mck_pkg::CodeUpperA && c <= mck_pkg::CodeUpperZ) begin
			pat = morse_pattern(int'(c - mck_pkg::CodeUpperA));
			for (int i = 0; i < pat.len(); i++) begin
				queue_segment(1'b1, 1'b1,
					(pat[i] == "-") ? seg_time[mck_pkg::REG_DASH] :
						seg_time[mck_pkg::REG_DOT], 1'b0);
				queue_segment(1'b0, 1'b1, seg_time[mck_pkg::REG_SYM_GAP], 1'b0);
			end
			queue_segment(1'b0, 1'b0, seg_time[mck_pkg::REG_LET_GAP], 1'b1);
		end
	endtask

	task automatic check_segment();
		seg_t want;
		n_segments++;
		if (segments_due.size() == 0) begin
			$error("unexpected segment: tone_on=%0b lamp_on=%0b duration=%0d last=%0b",
				tone_on, lamp_on, duration, last);
			err_count++;
		end else begin
			want = segments_due.pop_front();
			if (tone_on !== want.tone) begin
				$error("tone_on: expected %0b, got %0b", want.tone, tone_on);
				err_count++;
			end
			if (lamp_on !== want.lamp) begin
				$error("lamp_on: expected %0b, got %0b", want.lamp, lamp_on);
				err_count++;
			end
			if (duration !== want.dur) begin
				$error("duration: expected %0d, got %0d", want.dur, duration);
				err_count++;
			end
			if (last !== want.fin) begin
				$error("last: expected %0b, got %0b", want.fin, last);
				err_count++;
			end
		end
	endtask

	// driver: one character transaction at a time from the pending queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			char_code <= '0;
		end else begin
			if (in_valid && in_ready) begin
				predict_segments(char_code);
				n_chars++;
			end
			if (!in_valid || in_ready) begin
				if (pending_chars.size() > 0 && !send_hold &&
						$urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					char_code <= pending_chars.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each segment transaction, random backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				check_segment();
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic cfg_write(input mck_pkg::reg_idx_t idx,
			input logic [mck_pkg::DurW-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= mck_pkg::DataW'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		seg_time[idx] = val;
		pwrite <= 1'b0;
		penable <= 1'b0;
		// read back
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata[mck_pkg::DurW-1:0] !== val) begin
			$error("prdata: expected %0d, got %0d", val, prdata[mck_pkg::DurW-1:0]);
			err_count++;
		end
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_times(input logic [mck_pkg::DurW-1:0] dot,
			input logic [mck_pkg::DurW-1:0] dash,
			input logic [mck_pkg::DurW-1:0] sym_gap,
			input logic [mck_pkg::DurW-1:0] let_gap);
		cfg_write(mck_pkg::REG_DOT, dot);
		cfg_write(mck_pkg::REG_DASH, dash);
		cfg_write(mck_pkg::REG_SYM_GAP, sym_gap);
		cfg_write(mck_pkg::REG_LET_GAP, let_gap);
		n_settings++;
	endtask

	// wait until the keyer is idle and nothing is owed
	task automatic drain();
		while (pending_chars.size() > 0 || in_valid || segments_due.size() > 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic push_char(input logic [7:0] c);
		pending_chars.push_back(c);
	endtask

	function automatic logic [mck_pkg::DurW-1:0] rand_time();
		case ($urandom_range(3))
			0: return 16'd1;
			1: return 16'hFFFF;
			default: return mck_pkg::DurW'($urandom_range(65535, 1));
		endcase
	endfunction

	initial begin : stimulus
		string directed;
		int idle_tab [4];
		int stall_tab [4];
		int r;
		int n;
		idle_tab = '{0, 75, 0, 31};
		stall_tab = '{0, 0, 75, 31};
		seg_time[mck_pkg::REG_DOT] = mck_pkg::ResetShort;
		seg_time[mck_pkg::REG_DASH] = mck_pkg::ResetLong;
		seg_time[mck_pkg::REG_SYM_GAP] = mck_pkg::ResetShort;
		seg_time[mck_pkg::REG_LET_GAP] = mck_pkg::ResetLong;
		n_settings = 1;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset timing: case folding, boundaries, ignored bytes
		directed = "AzE TMHJQY0@[`{";
		for (int i = 0; i < directed.len(); i++)
			push_char(directed[i]);
		push_char(8'h00);
		push_char(8'h7F);
		push_char(8'h80);
		push_char(8'hFF);
		drain();

		// zero-length segments are emitted as written
		set_times(16'd0, 16'd0, 16'd0, 16'd0);
		push_char("B");
		push_char(mck_pkg::CodeSpace);
		drain();

		set_times(16'hFFFF, 16'd1, 16'hFFFF, 16'd1);
		push_char("y");
		push_char(mck_pkg::CodeSpace);
		drain();

		set_times(16'd1, 16'hFFFF, 16'd1, 16'hFFFF);
		push_char("Q");
		drain();

		for (int p = 0; p < 4; p++) begin
			set_times(rand_time(), rand_time(), rand_time(), rand_time());
			send_idle_pct = idle_tab[p];
			recv_stall_pct = stall_tab[p];
			for (int half = 0; half < 2; half++) begin
				n = 0;
				while (n < 33) begin
					r = $urandom_range(99);
					if (r < 12) begin
						push_char(8'($urandom_range(255)));
					end else begin
						if (r < 20)
							push_char(mck_pkg::CodeSpace);
						else
							push_char(mck_pkg::CodeUpperA + 8'($urandom_range(25)) +
								($urandom_range(1) ? mck_pkg::CaseOffset : 8'd0));
						n++;
					end
				end
				if (p == 3 && half == 0) begin
					// hold the sender until every owed segment is out
					while (pending_chars.size() > 0)
						@(negedge clk);
					send_hold = 1'b1;
					while (in_valid || segments_due.size() > 0)
						@(negedge clk);
					send_hold = 1'b0;
				end
			end
			drain();
		end

		repeat (16) @(negedge clk);
		if (segments_due.size() != 0) begin
			$error("%0d expected segments never arrived", segments_due.size());
			err_count++;
		end
		$display("Covered %0d characters and %0d segments over %0d timing settings,",
			n_chars, n_segments, n_settings);
		$display("with sender gaps, receiver stalls and a full drain pause mid-stream.");
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
